FILE: sv/u8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

	localparam int unsigned CP_W            = 21;
	localparam int unsigned LEN_W           = 3;
	localparam int unsigned RUNE_W          = 32;
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	localparam int unsigned MAX_RES  = 4;
	localparam int unsigned QDEPTH   = 8;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
	localparam int unsigned RES_W    = $clog2(MAX_RES + 1);

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

	localparam logic [7:0] ASCII_END   = 8'h80;
	localparam logic [7:0] LEAD_MIN    = 8'hC2;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] LEAD_END    = 8'hF5;
	localparam logic [7:0] LEAD_E0     = 8'hE0;
	localparam logic [7:0] LEAD_ED     = 8'hED;
	localparam logic [7:0] LEAD_F0     = 8'hF0;
	localparam logic [7:0] LEAD_F4     = 8'hF4;
	localparam logic [7:0] CONT_LO     = 8'h80;
	localparam logic [7:0] CONT_HI     = 8'hBF;
	localparam logic [7:0] CONT_LO_E0  = 8'hA0;
	localparam logic [7:0] CONT_HI_ED  = 8'h9F;
	localparam logic [7:0] CONT_LO_F0  = 8'h90;
	localparam logic [7:0] CONT_HI_F4  = 8'h8F;
	localparam logic [5:0] CONT_MASK   = 6'h3F;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic             bad;
		logic [LEN_W-1:0] len;
		logic             last;
		logic             done;
	} entry_t;

	typedef struct packed {
		logic             push;
		logic [RES_W-1:0] n;
	} push_t;

endpackage

FILE: sv/u8sd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and single-pass decode of one registered byte into up to
// four result entries.
// ----------------------------------------------------------------------------
module u8sd_decode import u8sd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic [7:0]   data_s1,
	input  logic         eos_s1,
	output entry_t       ent [MAX_RES],
	output push_t        push
);

	logic [7:0]       hb_q [3];
	logic [1:0]       hc_q;
	logic [LEN_W-1:0] el_q;

	logic             lead_prim;
	logic             lead_hold;
	logic [LEN_W-1:0] lead_el;
	entry_t           lead_ent;
	entry_t           err_ent;
	entry_t           prim_ent;
	logic             prim;
	logic [1:0]       e_cnt;
	logic [1:0]       f_cnt;
	logic [1:0]       hc_d;
	logic [LEN_W-1:0] el_d;
	logic             hold0;
	logic             store;
	logic [7:0]       lo;
	logic [7:0]       hi;
	logic             cont_ok;
	logic [CP_W-1:0]  asm_cp;
	logic [RES_W-1:0] n;

	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (hc_q == 2'd1) begin
			if (hb_q[0] == LEAD_E0) lo = CONT_LO_E0;
			if (hb_q[0] == LEAD_ED) hi = CONT_HI_ED;
			if (hb_q[0] == LEAD_F0) lo = CONT_LO_F0;
			if (hb_q[0] == LEAD_F4) hi = CONT_HI_F4;
		end
		cont_ok = (data_s1 >= lo) && (data_s1 <= hi);
	end

	always_comb begin
		case (el_q)
			3'd2:    asm_cp = {10'd0, hb_q[0][4:0], data_s1[5:0] & CONT_MASK};
			3'd3:    asm_cp = {5'd0, hb_q[0][3:0], hb_q[1][5:0], data_s1[5:0] & CONT_MASK};
			3'd4:    asm_cp = {hb_q[0][2:0], hb_q[1][5:0], hb_q[2][5:0],
			                   data_s1[5:0] & CONT_MASK};
			default: asm_cp = '0;
		endcase
	end

	always_comb begin
		err_ent      = '0;
		err_ent.code_point = REPL_CP;
		err_ent.bad  = 1'b1;
		err_ent.len  = LEN_W'(1);

		lead_ent  = err_ent;
		lead_prim = 1'b1;
		lead_hold = 1'b0;
		lead_el   = '0;
		if (data_s1 < ASCII_END) begin
			lead_ent.code_point = {13'd0, data_s1};
			lead_ent.bad        = 1'b0;
		end else if (data_s1 >= LEAD_MIN && data_s1 < LEAD_END) begin
			lead_prim = 1'b0;
			lead_hold = 1'b1;
			lead_el   = (data_s1 < LEAD3_MIN) ? LEN_W'(2) :
			            (data_s1 < LEAD4_MIN) ? LEN_W'(3) : LEN_W'(4);
		end

		prim     = 1'b0;
		prim_ent = lead_ent;
		e_cnt    = '0;
		hc_d     = hc_q;
		el_d     = el_q;
		hold0    = 1'b0;
		store    = 1'b0;

		if (hc_q == 2'd0) begin
			prim  = lead_prim;
			hold0 = lead_hold;
			hc_d  = lead_hold ? 2'd1 : 2'd0;
			el_d  = lead_el;
		end else if (cont_ok) begin
			if ({1'b0, hc_q} + 3'd1 >= el_q) begin
				prim = 1'b1;
				prim_ent.code_point = asm_cp;
				prim_ent.bad        = 1'b0;
				prim_ent.len        = el_q;
				hc_d = 2'd0;
				el_d = '0;
			end else begin
				store = 1'b1;
				hc_d  = hc_q + 2'd1;
			end
		end else begin
			e_cnt = hc_q;
			prim  = lead_prim;
			hold0 = lead_hold;
			hc_d  = lead_hold ? 2'd1 : 2'd0;
			el_d  = lead_el;
		end

		f_cnt = eos_s1 ? hc_d : 2'd0;
		if (eos_s1) begin
			hc_d = 2'd0;
			el_d = '0;
		end

		n = RES_W'(e_cnt) + RES_W'(prim) + RES_W'(f_cnt);

		for (int k = 0; k < MAX_RES; k++) begin
			ent[k]      = (prim && (RES_W'(k) == RES_W'(e_cnt))) ? prim_ent : err_ent;
			ent[k].last = (RES_W'(k) + RES_W'(1) == n);
			ent[k].done = eos_s1 && (RES_W'(k) + RES_W'(1) == n);
		end

		push.push = fire;
		push.n    = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= '0;
			el_q <= '0;
		end else if (fire) begin
			hc_q <= hc_d;
			el_q <= el_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hold0) hb_q[0] <= data_s1;
		if (fire && store) hb_q[hc_q] <= data_s1;
	end

endmodule

FILE: sv/u8sd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_queue
// Result queue: takes up to four entries per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
module u8sd_queue import u8sd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  entry_t  ent [MAX_RES],
	input  logic    pop,
	output entry_t  head,
	output logic    nonempty,
	output logic    room
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QCNT_W-1:0] add;
	logic [QCNT_W-1:0] sub;

	assign head     = mem_q[rd_q];
	assign nonempty = (cnt_q != '0);
	assign room     = (cnt_q <= QCNT_W'(QDEPTH - MAX_RES));
	assign add      = push.push ? QCNT_W'(push.n) : '0;
	assign sub      = pop ? QCNT_W'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.push) wr_q <= wr_q + QPTR_W'(push.n);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + add - sub;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RES; k++) begin
			if (push.push && (RES_W'(k) < push.n))
				mem_q[wr_q + QPTR_W'(k)] <= ent[k];
		end
	end

endmodule

FILE: sv/u8sd_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_tally
// Saturating per-stream result count and sticky stream validity.
// ----------------------------------------------------------------------------
module u8sd_tally import u8sd_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop,
	input  entry_t            head,
	output logic [RUNE_W-1:0] rune_total,
	output logic              stream_valid
);

	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_nxt;
	logic                   ok_q;

	assign cnt_nxt      = (&cnt_q) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign stream_valid = head.done && ok_q && !head.bad;

	generate
		if (COUNT_WIDTH >= RUNE_W) begin : g_trunc
			assign rune_total = cnt_nxt[RUNE_W-1:0];
		end else begin : g_ext
			assign rune_total = {{(RUNE_W - COUNT_WIDTH){1'b0}}, cnt_nxt};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ok_q  <= 1'b1;
		end else if (pop) begin
			if (head.done) begin
				cnt_q <= '0;
				ok_q  <= 1'b1;
			end else begin
				cnt_q <= cnt_nxt;
				ok_q  <= ok_q && !head.bad;
			end
		end
	end

endmodule

FILE: sv/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// A result passes the input register and then the result queue to the output.
// Throughput: 1 byte per cycle while each byte gives at most one result and
//   rune_stall is low; results leave one per cycle through an 8-entry queue,
//   and input stalls once fewer than 4 queue entries are free. Reset: arst_n
//   clears the input valid flag, sequence state, queue and tally; held sequence
//   bytes are not reset.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder and validator, one byte per item.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import u8sd_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        data_byte,
	input  logic              end_of_stream,
	output logic              rune_valid,
	input  logic              rune_stall,
	output logic [CP_W-1:0]   code_point,
	output logic              bad_sequence,
	output logic [LEN_W-1:0]  seq_len,
	output logic              last_of_run,
	output logic              stream_done,
	output logic              stream_valid,
	output logic [RUNE_W-1:0] rune_total
);

	logic       vld_s1;
	logic [7:0] data_s1;
	logic       eos_s1;
	logic       room;
	logic       fire;
	logic       pop;
	entry_t     ent [MAX_RES];
	push_t      push;
	entry_t     head;

	assign fire       = vld_s1 && room;
	assign byte_stall = vld_s1 && !room;
	assign pop        = rune_valid && !rune_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	u8sd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.data_s1 (data_s1),
		.eos_s1  (eos_s1),
		.ent     (ent),
		.push    (push)
	);

	u8sd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.ent      (ent),
		.pop      (pop),
		.head     (head),
		.nonempty (rune_valid),
		.room     (room)
	);

	u8sd_tally #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.head         (head),
		.rune_total   (rune_total),
		.stream_valid (stream_valid)
	);

	assign code_point   = head.code_point;
	assign bad_sequence = head.bad;
	assign seq_len      = head.len;
	assign last_of_run  = head.last;
	assign stream_done  = head.done;

endmodule

FILE: sv/u8sd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8sd_checker import u8sd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rune_valid,
	input logic              rune_stall,
	input logic [CP_W-1:0]   code_point,
	input logic              bad_sequence,
	input logic [LEN_W-1:0]  seq_len,
	input logic              last_of_run,
	input logic              stream_done,
	input logic              stream_valid,
	input logic [RUNE_W-1:0] rune_total
);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rune_valid && stream_done |-> last_of_run)
		else $error("stream end result not last of its byte");

	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		rune_valid && bad_sequence |-> code_point == REPL_CP && seq_len == LEN_W'(1))
		else $error("error result malformed");

	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rune_valid && stream_valid |-> stream_done && !bad_sequence)
		else $error("stream valid outside clean stream end");

	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		rune_valid && !rune_stall && stream_done ##1 rune_valid |-> rune_total == RUNE_W'(1))
		else $error("count not restarted after stream end");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rune_valid && rune_stall |=> rune_valid && $stable(code_point) && $stable(rune_total))
		else $error("stalled result changed");

endmodule

bind utf8_stream_decoder u8sd_checker u_chk (.*);
